// ----- hdl/tiled_cholesky_task_sequencer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tiled Cholesky task sequencer
// Immediate-implication and next-cycle forms, reset held off.
// ----------------------------------------------------------------------------
`ifndef TILED_CHOLESKY_TASK_SEQUENCER_ASSERT_SVH
`define TILED_CHOLESKY_TASK_SEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCTS_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCTS_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tcts_pkg.sv -----
// ----------------------------------------------------------------------------
// tcts_pkg
// Shared types, codes and the record expansion function of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcts_pkg;

    localparam int unsigned MAX_TILES_DEFAULT = 64;
    localparam int unsigned QUEUE_DEPTH       = 4;

    typedef enum logic [2:0] {
        KIND_NONE        = 3'd0,
        KIND_DIAG_UPDATE = 3'd1,
        KIND_DIAG_FACTOR = 3'd2,
        KIND_OFF_UPDATE  = 3'd3,
        KIND_SOLVE       = 3'd4
    } task_kind_t;

    typedef enum logic [1:0] {
        REC_TASK = 2'd0,
        REC_DEP  = 2'd1,
        REC_DONE = 2'd2
    } rec_kind_t;

    localparam logic [1:0] REG_TILE_COUNT = 2'd0;

    // One issued task, or a done marker, as handed from front to back.
    typedef struct packed {
        logic       done;
        task_kind_t kind;
        logic [5:0] row;
        logic [5:0] col;
        logic [5:0] inner;
    } desc_t;

    typedef struct packed {
        rec_kind_t  rec_kind;
        task_kind_t task_kind;
        logic [5:0] label_first;
        logic [5:0] label_second;
        logic [5:0] label_third;
        logic [1:0] dep_count;
        logic       last;
    } rec_t;

    function automatic rec_t mk_rec(rec_kind_t rk, task_kind_t tk, logic [5:0] a,
                                    logic [5:0] b, logic [5:0] c, logic [1:0] cnt);
        rec_t r;
        r.rec_kind     = rk;
        r.task_kind    = tk;
        r.label_first  = a;
        r.label_second = b;
        r.label_third  = c;
        r.dep_count    = cnt;
        r.last         = 1'b0;
        return r;
    endfunction

    // Number of records a descriptor expands into (1 to 4).
    function automatic logic [2:0] rec_total(desc_t d);
        logic [2:0] n;
        n = 3'd1;
        if (!d.done) begin
            case (d.kind)
                KIND_DIAG_UPDATE: n = (d.inner != 6'd0) ? 3'd3 : 3'd2;
                KIND_DIAG_FACTOR: n = (d.col != 6'd0) ? 3'd2 : 3'd1;
                KIND_OFF_UPDATE:  n = (d.inner != 6'd0) ? 3'd4 : 3'd3;
                KIND_SOLVE:       n = (d.col != 6'd0) ? 3'd3 : 3'd2;
                default:          n = 3'd1;
            endcase
        end
        return n;
    endfunction

    // Record number idx of descriptor d; task record first, then predecessors.
    function automatic rec_t expand(desc_t d, logic [1:0] idx);
        rec_t       r;
        logic [2:0] n;
        logic [1:0] cnt;
        n   = rec_total(d);
        cnt = 2'(n - 3'd1);
        r   = mk_rec(REC_DONE, KIND_NONE, 6'd0, 6'd0, 6'd0, 2'd0);
        if (!d.done) begin
            case (d.kind)
                KIND_DIAG_UPDATE: begin
                    case (idx)
                        2'd0:    r = mk_rec(REC_TASK, KIND_DIAG_UPDATE, 6'd0, d.col,
                                            d.inner, cnt);
                        2'd1:    r = mk_rec(REC_DEP, KIND_SOLVE, 6'd0, d.col, d.inner, 2'd0);
                        default: r = mk_rec(REC_DEP, KIND_DIAG_UPDATE, 6'd0, d.col,
                                            d.inner - 6'd1, 2'd0);
                    endcase
                end
                KIND_DIAG_FACTOR: begin
                    case (idx)
                        2'd0:    r = mk_rec(REC_TASK, KIND_DIAG_FACTOR, 6'd0, 6'd0, d.col,
                                            cnt);
                        default: r = mk_rec(REC_DEP, KIND_DIAG_UPDATE, 6'd0, d.col,
                                            d.col - 6'd1, 2'd0);
                    endcase
                end
                KIND_OFF_UPDATE: begin
                    case (idx)
                        2'd0:    r = mk_rec(REC_TASK, KIND_OFF_UPDATE, d.row, d.col,
                                            d.inner, cnt);
                        2'd1:    r = mk_rec(REC_DEP, KIND_SOLVE, 6'd0, d.col, d.inner, 2'd0);
                        2'd2:    r = mk_rec(REC_DEP, KIND_SOLVE, 6'd0, d.row, d.inner, 2'd0);
                        default: r = mk_rec(REC_DEP, KIND_OFF_UPDATE, d.row, d.col,
                                            d.inner - 6'd1, 2'd0);
                    endcase
                end
                default: begin
                    case (idx)
                        2'd0:    r = mk_rec(REC_TASK, KIND_SOLVE, 6'd0, d.row, d.col, cnt);
                        2'd1:    r = mk_rec(REC_DEP, KIND_DIAG_FACTOR, 6'd0, 6'd0, d.col,
                                            2'd0);
                        default: r = mk_rec(REC_DEP, KIND_OFF_UPDATE, d.row, d.col,
                                            d.col - 6'd1, 2'd0);
                    endcase
                end
            endcase
        end
        r.last = ({1'b0, idx} == 3'(n - 3'd1));
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tiled_cholesky_task_sequencer.sv -----
// ----------------------------------------------------------------------------
// tiled_cholesky_task_sequencer
// Task record generator for a blocked lower Cholesky factorization.
// ----------------------------------------------------------------------------
// Each transfer on the s_ side with s_tdata[0] high asks for the next task of
// the right-looking tiled Cholesky walk over an N x N tile grid (N from the
// tile_count register at address 0, clamped to 1..MAX_TILES). The block
// answers with a task record (m_tuser = 0) carrying the task kind, its three
// label indices and its static predecessor count, followed by one dependency
// record (m_tuser = 1) per predecessor; m_tlast marks the final record of the
// request. After the last diagonal factor every request returns a single done
// record (m_tuser = 2). A transfer with s_tdata[0] low is taken and dropped.
// Rate: the front takes one request per cycle while its four-entry descriptor
// queue has room; the back drains one record per cycle while m_tready is high,
// and a request expands into 1 to 4 records (4 for an off-diagonal update with
// k > 0). The record expansion in the back sets the sustained rate. Write
// tile_count only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tiled_cholesky_task_sequencer #(
    parameter int unsigned MAX_TILES = tcts_pkg::MAX_TILES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] request, [7:1] zero
    // record stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [2:0] task_kind, [8:3] label_first,
                                        // [14:9] label_second, [20:15] label_third,
                                        // [22:21] dependency_count, [23] zero
    output logic [1:0]       m_tuser,   // [1:0] record_kind
    output logic             m_tlast,   // last_record
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [6:0]      tile_count_reg, tile_count_next;
    logic            reg_hit;
    logic            push, pop, queue_empty, queue_full;
    tcts_pkg::desc_t push_data, head;
    tcts_pkg::rec_t  rec;

    // Register file: a single word, tile_count, at byte address zero.
    assign pready  = 1'b1;
    assign reg_hit = ({1'b0, paddr[2]} == tcts_pkg::REG_TILE_COUNT);
    assign prdata  = reg_hit ? {25'd0, tile_count_reg} : 32'd0;

    always_comb begin
        tile_count_next = tile_count_reg;
        if (psel && penable && pwrite && pready && reg_hit) begin
            tile_count_next = pwdata[6:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_count_reg <= 7'd3;
        end else begin
            tile_count_reg <= tile_count_next;
        end
    end

    // Front: accept requests and advance the task walk.
    tcts_front #(
        .MAX_TILES (MAX_TILES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tile_count (tile_count_reg),
        .req_valid  (s_tvalid),
        .req_bit    (s_tdata[0]),
        .req_ready  (s_tready),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // Decouple the walk from the record drain.
    tcts_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    // Back: expand each descriptor into its records.
    tcts_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_rec     (rec)
    );

    assign m_tdata = {1'b0, rec.dep_count, rec.label_third, rec.label_second,
                      rec.label_first, rec.task_kind};
    assign m_tuser = rec.rec_kind;
    assign m_tlast = rec.last;

endmodule

`default_nettype wire

// ----- hdl/tcts_queue.sv -----
// ----------------------------------------------------------------------------
// tcts_queue
// Small register FIFO of task descriptors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tcts_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire tcts_pkg::desc_t push_data,
    input  wire logic            pop,
    output tcts_pkg::desc_t      head,
    output logic                 empty,
    output logic                 full
);

    localparam int unsigned DEPTH = tcts_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tcts_pkg::desc_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == CNT_W'(0));
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tcts_front.sv -----
// ----------------------------------------------------------------------------
// tcts_front
// Take requests, walk the task order and issue one descriptor per request.
// ----------------------------------------------------------------------------
`default_nettype none

module tcts_front #(
    parameter int unsigned MAX_TILES = tcts_pkg::MAX_TILES_DEFAULT
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [6:0]      tile_count,
    input  wire logic            req_valid,
    input  wire logic            req_bit,
    output logic                 req_ready,
    input  wire logic            queue_full,
    output logic                 push,
    output tcts_pkg::desc_t      push_data
);

    tcts_pkg::task_kind_t phase_reg, phase_next;
    logic [6:0] row_reg, row_next;
    logic [5:0] col_reg, col_next;
    logic [5:0] inner_reg, inner_next;
    logic       all_issued_reg, all_issued_next;
    logic [6:0] n_eff;
    logic       finish;

    assign req_ready = !queue_full;

    // Clamp the tile count to 1..MAX_TILES.
    always_comb begin
        if (tile_count == 7'd0) begin
            n_eff = 7'd1;
        end else if (32'(tile_count) > 32'(MAX_TILES)) begin
            n_eff = 7'(MAX_TILES);
        end else begin
            n_eff = tile_count;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        inner_next      = inner_reg;
        all_issued_next = all_issued_reg;
        finish          = 1'b0;
        push            = 1'b0;
        push_data       = '0;
        if (req_valid && req_ready && req_bit) begin
            push = 1'b1;
            if (all_issued_reg) begin
                push_data.done = 1'b1;
            end else begin
                unique case (phase_reg)
                    tcts_pkg::KIND_NONE: begin
                        phase_next = tcts_pkg::KIND_DIAG_FACTOR;
                    end
                    tcts_pkg::KIND_DIAG_UPDATE, tcts_pkg::KIND_OFF_UPDATE: begin
                        if ({1'b0, inner_reg} + 7'd1 < {1'b0, col_reg}) begin
                            inner_next = inner_reg + 6'd1;
                        end else begin
                            inner_next = 6'd0;
                            phase_next = (phase_reg == tcts_pkg::KIND_DIAG_UPDATE) ?
                                         tcts_pkg::KIND_DIAG_FACTOR : tcts_pkg::KIND_SOLVE;
                        end
                    end
                    tcts_pkg::KIND_DIAG_FACTOR: begin
                        if (col_reg != 6'd0) begin
                            if ({1'b0, col_reg} + 7'd1 < n_eff) begin
                                phase_next = tcts_pkg::KIND_OFF_UPDATE;
                            end else begin
                                all_issued_next = 1'b1;
                                finish          = 1'b1;
                            end
                        end else begin
                            phase_next = tcts_pkg::KIND_SOLVE;
                        end
                    end
                    tcts_pkg::KIND_SOLVE: begin
                        if ({1'b0, row_reg} + 8'd1 < {1'b0, n_eff}) begin
                            row_next   = row_reg + 7'd1;
                            phase_next = (col_reg != 6'd0) ?
                                         tcts_pkg::KIND_OFF_UPDATE : tcts_pkg::KIND_SOLVE;
                        end else begin
                            col_next   = col_reg + 6'd1;
                            row_next   = {1'b0, col_reg + 6'd1} + 7'd1;
                            phase_next = tcts_pkg::KIND_DIAG_UPDATE;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
                if (finish) begin
                    push_data.done = 1'b1;
                end else begin
                    push_data.kind  = phase_next;
                    push_data.row   = row_next[5:0];
                    push_data.col   = col_next;
                    push_data.inner = inner_next;
                    if (phase_next == tcts_pkg::KIND_DIAG_FACTOR &&
                        {1'b0, col_next} + 7'd1 >= n_eff) begin
                        all_issued_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= tcts_pkg::KIND_NONE;
            row_reg        <= 7'd1;
            col_reg        <= 6'd0;
            inner_reg      <= 6'd0;
            all_issued_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            inner_reg      <= inner_next;
            all_issued_reg <= all_issued_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tcts_back.sv -----
// ----------------------------------------------------------------------------
// tcts_back
// Expand queued descriptors into records, one record per cycle while the output is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tcts_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire tcts_pkg::desc_t head,
    input  wire logic            queue_empty,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output tcts_pkg::rec_t       out_rec
);

    logic           valid_reg, valid_next;
    tcts_pkg::rec_t rec_reg;
    tcts_pkg::rec_t rec_cur;
    logic [1:0]     idx_reg, idx_next;
    logic           load;

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;
    assign rec_cur   = tcts_pkg::expand(head, idx_reg);
    assign load      = !queue_empty && (!valid_reg || out_ready);
    assign pop       = load && rec_cur.last;

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = rec_cur.last ? 2'd0 : idx_reg + 2'd1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload: load only, no reset.
    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg <= rec_cur;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tcts_checker.sv -----
// ----------------------------------------------------------------------------
// tcts_checker
// Port-level checks on the record stream of the task sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tiled_cholesky_task_sequencer_assert.svh"

module tcts_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    logic [26:0] m_rec;
    logic        stalled;
    logic        is_done, is_task, is_dep;
    logic        done_ok, task_ok, dep_ok;

    assign m_rec   = {m_tlast, m_tuser, m_tdata};
    assign stalled = m_tvalid && !m_tready;
    assign is_done = m_tvalid && (m_tuser == tcts_pkg::REC_DONE);
    assign is_task = m_tvalid && (m_tuser == tcts_pkg::REC_TASK);
    assign is_dep  = m_tvalid && (m_tuser == tcts_pkg::REC_DEP);
    // done record: single record, all payload zero
    assign done_ok = m_tlast && (m_tdata == 24'd0);
    // task record ends the request exactly when it has no predecessors
    assign task_ok = (m_tlast == (m_tdata[22:21] == 2'd0));
    // dependency record names a real task and carries no count
    assign dep_ok  = (m_tdata[2:0] != 3'd0) && (m_tdata[22:21] == 2'd0);

    `TCTS_ASSERT_NOW(a_done_shape, aclk, aresetn, is_done, done_ok, "bad done record")

    `TCTS_ASSERT_NOW(a_task_last, aclk, aresetn, is_task, task_ok, "task last flag off")

    `TCTS_ASSERT_NOW(a_dep_shape, aclk, aresetn, is_dep, dep_ok, "bad dependency record")

    // A stalled record holds.
    `TCTS_ASSERT_NEXT(a_hold, aclk, aresetn, stalled, m_tvalid && $stable(m_rec), "record changed")

endmodule

bind tiled_cholesky_task_sequencer tcts_checker u_tcts_checker (.*);

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the tiled Cholesky task sequencer
// Drives request transfers and tile-count writes, predicts every record of the
// tiled Cholesky walk in step with the block, and checks each record field by
// field under random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------

module testbench;

    // One output record as seen on the m_ side.
    typedef struct packed {
        tcts_pkg::rec_kind_t  rkind;
        tcts_pkg::task_kind_t tkind;
        logic [5:0]           label_first;
        logic [5:0]           label_second;
        logic [5:0]           label_third;
        logic [1:0]           dep_count;
        logic                 last_rec;
    } record_t;

    typedef enum logic [1:0] {
        ROW_REQUEST,
        ROW_IDLE,
        ROW_SET_COUNT
    } row_op_t;

    typedef struct packed {
        row_op_t    op;
        logic [6:0] count;   // tile_count value for ROW_SET_COUNT rows
        logic       typed;   // expected record given below instead of predicted
        record_t    want;
    } stim_row_t;

    localparam record_t NO_RECORD    = '0;
    localparam record_t FIRST_FACTOR = '{tcts_pkg::REC_TASK, tcts_pkg::KIND_DIAG_FACTOR,
                                         6'd0, 6'd0, 6'd0, 2'd0, 1'b1};
    localparam record_t DONE_RECORD  = '{tcts_pkg::REC_DONE, tcts_pkg::KIND_NONE,
                                         6'd0, 6'd0, 6'd0, 2'd0, 1'b1};
    localparam logic [2:0] TILE_COUNT_ADDR = 3'({tcts_pkg::REG_TILE_COUNT, 2'b00});
    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_REQUESTS = 45;
    localparam int LONG_HOLD      = 150;

    // Directed part: start from the reset count of 3 and walk the first
    // columns, then raise the count mid-run (to the 7-bit extreme, to the
    // clamp value and just past it) so the walk carries on into deeper
    // columns with off-diagonal updates that have a preceding update.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_IDLE,      7'd0,   1'b0, NO_RECORD},     // empty request before any task
        '{ROW_REQUEST,   7'd0,   1'b1, FIRST_FACTOR},  // factor (0,0,0), no predecessor
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},     // solve (0,1,0)
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},     // solve (0,2,0)
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},     // diag update (0,1,0)
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},     // factor (0,0,1)
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},     // offdiag update (2,1,0)
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},     // solve (0,2,1)
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},     // diag update (0,2,0)
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},     // diag update (0,2,1)
        '{ROW_SET_COUNT, 7'd127, 1'b0, NO_RECORD},     // above the clamp: acts as 64
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},     // factor (0,0,2), run goes on
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},     // offdiag update (3,2,0)
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},     // offdiag update (3,2,1), 4 records
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},     // solve (0,3,2)
        '{ROW_IDLE,      7'd0,   1'b0, NO_RECORD},
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},
        '{ROW_SET_COUNT, 7'd64,  1'b0, NO_RECORD},
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},
        '{ROW_SET_COUNT, 7'd65,  1'b0, NO_RECORD},
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD},
        '{ROW_REQUEST,   7'd0,   1'b0, NO_RECORD}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [0] request, [7:1] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [2:0] task_kind, [8:3] label_first,
                                    // [14:9] label_second, [20:15] label_third,
                                    // [22:21] dependency_count, [23] zero
    logic [1:0]  m_tuser;           // [1:0] record_kind
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Walk state of the predictor, mirrored from the block's task walk.
    tcts_pkg::task_kind_t walk_kind = tcts_pkg::KIND_NONE;
    int          walk_row   = 1;
    int          walk_col   = 0;
    int          walk_inner = 0;
    bit          walk_done  = 1'b0;
    logic [6:0]  count_setting = 7'd3;

    record_t     expected_records [$];

    // Typed expectation travelling with the transfer on offer.
    logic        typed_row  = 1'b0;
    record_t     typed_want = '0;

    bit          tx_idle_en     = 1'b0;
    bit          rx_idle_en     = 1'b0;
    bit          hold_requested = 1'b0;
    bit          hold_started   = 1'b0;

    int          fail_count      = 0;
    int          records_checked = 0;
    int          task_requests   = 0;
    int          empty_requests  = 0;
    int          count_writes    = 0;
    bit          done_seen       = 1'b0;

    tiled_cholesky_task_sequencer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Hard limit on the run: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAIL tiled_cholesky_task_sequencer");
        $finish;
    end

    function automatic record_t make_record(tcts_pkg::rec_kind_t rk, tcts_pkg::task_kind_t tk,
                                            int a, int b, int c, int deps);
        record_t r;
        r.rkind        = rk;
        r.tkind        = tk;
        r.label_first  = 6'(a);
        r.label_second = 6'(b);
        r.label_third  = 6'(c);
        r.dep_count    = 2'(deps);
        r.last_rec     = 1'b0;
        return r;
    endfunction

    // Advance the walk by one request and list the records it produces.
    function automatic int plan_request(input logic req, output record_t recs [4]);
        int n;
        int i;
        int j;
        int k;
        int c;
        n = (count_setting == 7'd0) ? 1 : ((count_setting > 7'd64) ? 64 : int'(count_setting));
        for (c = 0; c < 4; c++) begin
            recs[c] = '0;
        end
        if (!req) return 0;
        if (walk_done) begin
            recs[0] = DONE_RECORD;
            return 1;
        end

        case (walk_kind)
            tcts_pkg::KIND_NONE: begin
                walk_kind = tcts_pkg::KIND_DIAG_FACTOR;
            end
            tcts_pkg::KIND_DIAG_UPDATE, tcts_pkg::KIND_OFF_UPDATE: begin
                if (walk_inner + 1 < walk_col) begin
                    walk_inner++;
                end else begin
                    walk_inner = 0;
                    if (walk_kind == tcts_pkg::KIND_DIAG_UPDATE) begin
                        walk_kind = tcts_pkg::KIND_DIAG_FACTOR;
                    end else begin
                        walk_kind = tcts_pkg::KIND_SOLVE;
                    end
                end
            end
            tcts_pkg::KIND_DIAG_FACTOR: begin
                if (walk_col == 0) begin
                    walk_kind = tcts_pkg::KIND_SOLVE;
                end else if (walk_col + 1 < n) begin
                    walk_kind = tcts_pkg::KIND_OFF_UPDATE;
                end else begin
                    // count dropped under the column after its factor: finish here
                    walk_done = 1'b1;
                    recs[0] = DONE_RECORD;
                    return 1;
                end
            end
            default: begin
                if (walk_row + 1 < n) begin
                    walk_row++;
                    if (walk_col > 0) walk_kind = tcts_pkg::KIND_OFF_UPDATE;
                    else walk_kind = tcts_pkg::KIND_SOLVE;
                end else begin
                    walk_col  = (walk_col + 1) % 64;
                    walk_row  = walk_col + 1;
                    walk_kind = tcts_pkg::KIND_DIAG_UPDATE;
                end
            end
        endcase

        i = walk_row;
        j = walk_col;
        k = walk_inner;
        case (walk_kind)
            tcts_pkg::KIND_DIAG_UPDATE: begin
                recs[0] = make_record(tcts_pkg::REC_TASK, tcts_pkg::KIND_DIAG_UPDATE, 0, j, k,
                                      (k == 0) ? 1 : 2);
                recs[1] = make_record(tcts_pkg::REC_DEP, tcts_pkg::KIND_SOLVE, 0, j, k, 0);
                c = 2;
                if (k > 0) begin
                    recs[2] = make_record(tcts_pkg::REC_DEP, tcts_pkg::KIND_DIAG_UPDATE, 0, j,
                                          k - 1, 0);
                    c = 3;
                end
            end
            tcts_pkg::KIND_DIAG_FACTOR: begin
                recs[0] = make_record(tcts_pkg::REC_TASK, tcts_pkg::KIND_DIAG_FACTOR, 0, 0, j,
                                      (j == 0) ? 0 : 1);
                c = 1;
                if (j > 0) begin
                    recs[1] = make_record(tcts_pkg::REC_DEP, tcts_pkg::KIND_DIAG_UPDATE, 0, j,
                                          j - 1, 0);
                    c = 2;
                end
            end
            tcts_pkg::KIND_OFF_UPDATE: begin
                recs[0] = make_record(tcts_pkg::REC_TASK, tcts_pkg::KIND_OFF_UPDATE, i, j, k,
                                      (k == 0) ? 2 : 3);
                recs[1] = make_record(tcts_pkg::REC_DEP, tcts_pkg::KIND_SOLVE, 0, j, k, 0);
                recs[2] = make_record(tcts_pkg::REC_DEP, tcts_pkg::KIND_SOLVE, 0, i, k, 0);
                c = 3;
                if (k > 0) begin
                    recs[3] = make_record(tcts_pkg::REC_DEP, tcts_pkg::KIND_OFF_UPDATE, i, j,
                                          k - 1, 0);
                    c = 4;
                end
            end
            default: begin
                recs[0] = make_record(tcts_pkg::REC_TASK, tcts_pkg::KIND_SOLVE, 0, i, j,
                                      (j == 0) ? 1 : 2);
                recs[1] = make_record(tcts_pkg::REC_DEP, tcts_pkg::KIND_DIAG_FACTOR, 0, 0, j,
                                      0);
                c = 2;
                if (j > 0) begin
                    recs[2] = make_record(tcts_pkg::REC_DEP, tcts_pkg::KIND_OFF_UPDATE, i, j,
                                          j - 1, 0);
                    c = 3;
                end
            end
        endcase
        recs[c - 1].last_rec = 1'b1;

        if (walk_kind == tcts_pkg::KIND_DIAG_FACTOR && j + 1 >= n) walk_done = 1'b1;
        return c;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Scoreboard: predict on each accepted request, then check each accepted
    // record against the oldest expectation. Input side first, so each record's
    // expectation is queued before the record is checked.
    always @(posedge aclk) begin : scoreboard
        record_t planned [4];
        record_t want;
        int      planned_n;
        if (aresetn && s_tvalid && s_tready) begin
            planned_n = plan_request(s_tdata[0], planned);
            if (typed_row) begin
                expected_records.push_back(typed_want);
            end else begin
                for (int r = 0; r < planned_n; r++) begin
                    expected_records.push_back(planned[r]);
                end
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_records.size() == 0) begin
                $error("record with nothing expected: kind %0d, tdata %h", m_tuser, m_tdata);
                fail_count++;
            end else begin
                want = expected_records.pop_front();
                check_field("record_kind", 8'(want.rkind), 8'(m_tuser));
                check_field("task_kind", 8'(want.tkind), 8'(m_tdata[2:0]));
                check_field("label_first", 8'(want.label_first), 8'(m_tdata[8:3]));
                check_field("label_second", 8'(want.label_second), 8'(m_tdata[14:9]));
                check_field("label_third", 8'(want.label_third), 8'(m_tdata[20:15]));
                check_field("dependency_count", 8'(want.dep_count), 8'(m_tdata[22:21]));
                check_field("last_record", 8'(want.last_rec), 8'(m_tlast));
                if (want.rkind == tcts_pkg::REC_DONE) done_seen = 1'b1;
            end
            records_checked++;
        end
    end

    // Record sink: drive m_tready at the falling edge. Take random stall
    // bursts when enabled, and one long hold-off when the stimulus asks for
    // it, counted here so the sender keeps offering meanwhile.
    initial begin : record_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left == 0 && hold_requested && !hold_started) begin
                hold_started = 1'b1;
                stall_left   = LONG_HOLD;
            end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one request transfer and hold it until taken. Called and left at
    // a falling edge.
    task automatic send_request(input logic req, input logic typed, input record_t want);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {7'd0, req};
        typed_row  <= typed;
        typed_want <= want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (req) task_requests++;
        else empty_requests++;
    endtask

    // Write tile_count once the block has drained, then read it back.
    task automatic set_tile_count(input logic [6:0] value);
        s_tvalid <= 1'b0;
        while (expected_records.size() != 0) @(negedge aclk);
        // let any dropped request clear the front end
        repeat (8) @(negedge aclk);

        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= TILE_COUNT_ADDR;
        pwdata  <= {25'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        count_setting = value;
        count_writes++;

        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[6:0] !== value) begin
            $error("tile_count readback: expected %0d, got %0d", value, prdata[6:0]);
            fail_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin : stimulus
        int guard;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table, both sides idling at random.
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            case (directed_rows[r].op)
                ROW_SET_COUNT: set_tile_count(directed_rows[r].count);
                ROW_IDLE:      send_request(1'b0, 1'b0, NO_RECORD);
                default:       send_request(1'b1, directed_rows[r].typed, directed_rows[r].want);
            endcase
        end

        // Random phases: a fresh count each time, kept well above the column
        // reached so the walk stays alive; vary the idling per phase.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_tile_count(7'($urandom_range(16, 127)));
            tx_idle_en = (p == 0) || (p == 3) || (p == 4);
            rx_idle_en = (p == 0) || (p == 2) || (p == 3);
            // fill the block against a long output stall with no input gaps
            if (p == 2) hold_requested = 1'b1;
            for (int q = 0; q < PHASE_REQUESTS; q++) begin
                if ($urandom_range(0, 9) == 0) send_request(1'b0, 1'b0, NO_RECORD);
                send_request(1'b1, 1'b0, NO_RECORD);
            end
        end

        // Closing stretch, no idling: shrink the count so the next column's
        // factor is the second to last, stop right after it, then drop the
        // count to zero (acts as one) so the following step finishes the run.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        set_tile_count(7'(walk_col + 3));
        guard = 0;
        while (!(walk_kind == tcts_pkg::KIND_DIAG_FACTOR && walk_col > 0) && guard < 200) begin
            send_request(1'b1, 1'b0, NO_RECORD);
            guard++;
        end
        set_tile_count(7'd0);
        send_request(1'b1, 1'b0, NO_RECORD);
        for (int q = 0; q < 12; q++) begin
            if (q % 4 == 1) send_request(1'b0, 1'b0, NO_RECORD);
            send_request(1'b1, 1'b1, DONE_RECORD);
        end
        s_tvalid <= 1'b0;

        // Drain, then keep watching for stray records.
        while (expected_records.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);

        $display("Run covered %0d task requests and %0d empty requests over %0d count writes.",
                 task_requests, empty_requests, count_writes);
        $display("Checked %0d records; long output stall %0s; done state %0s.",
                 records_checked, hold_started ? "taken" : "missed",
                 done_seen ? "reached" : "not reached");
        if (fail_count == 0) begin
            $display("PASS tiled_cholesky_task_sequencer");
        end else begin
            $display("FAIL tiled_cholesky_task_sequencer");
        end
        $finish;
    end

endmodule
